/* hw/rtl/sfcs_pkg.sv */
package sfcs_pkg;

   localparam int ADDR_W = 24;
   localparam logic [ADDR_W-1:0] ADDR_MAX = 24'hFF_FFFF;

   localparam logic [7:0] OP_NONE         = 8'h00;
   localparam logic [7:0] OP_PROGRAM      = 8'h02;
   localparam logic [7:0] OP_READ         = 8'h03;
   localparam logic [7:0] OP_WRDI         = 8'h04;
   localparam logic [7:0] OP_RDSR         = 8'h05;
   localparam logic [7:0] OP_WREN         = 8'h06;
   localparam logic [7:0] OP_FAST_READ    = 8'h0B;
   localparam logic [7:0] OP_SECTOR_ERASE = 8'h20;
   localparam logic [7:0] OP_CHIP_ERASE   = 8'hC7;

   localparam logic [7:0] IDLE_BYTE    = 8'hFF;
   localparam logic [7:0] STATUS_WEL   = 8'h02;
   localparam logic [7:0] STATUS_CLEAR = 8'h00;

   localparam logic [2:0] PHASE_MAX  = 3'd5;
   localparam logic [2:0] PHASE_ADDR = 3'd3;
   localparam logic [2:0] PHASE_DMY  = 3'd4;

endpackage

/* hw/rtl/spi_flash_command_slave_core.sv */
// Channel | Ports                                   | Handshake
// --------+-----------------------------------------+------------------------------
// request | start, busy, req_func, req_mosi_byte    | word taken when start && !busy
// result  | rsp_strobe, rsp_miso_byte               | word valid one cycle, strobed
// csr     | csr_valid, csr_ready, csr_wdata         | written when valid && ready
//
// An exchange answers in the next cycle, but a read data byte is first read
// from memory; a deselect answers nothing. A program data byte is read, then
// ANDed and written back. The third address byte waits on a remainder; a sector
// erase on two, then writes the sector; a chip erase all (one write a cycle).
// Reset: a clearing pass writes 0xFF to all MEM_BYTES entries with busy high;
// csr writes are taken throughout. The receiver cannot stall.
module spi_flash_command_slave_core #(
   parameter int MEM_BYTES    = 65536,
   parameter int SECTOR_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_func,
   input  logic [7:0] req_mosi_byte,
   output logic       rsp_strobe,
   output logic [7:0] rsp_miso_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_wdata
);
   import sfcs_pkg::*;

   localparam int CELL_W = $clog2(MEM_BYTES);
   localparam int SEC_W  = $clog2(SECTOR_BYTES);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_MREM, ST_SREM, ST_SREM2, ST_SWEEP, ST_PWR, ST_RDATA
   } state_type;

   state_type         state_ff, state_in;
   logic              present_ff, present_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [2:0]        phase_ff, phase_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              latch_ff, latch_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [SEC_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        mosi_ff, mosi_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]        rsp_miso_ff, rsp_miso_in;

   // flash array: one port, read data registered
   logic [7:0]        mem [MEM_BYTES];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [7:0]        mem_wdata;

   // remainder units for the sector base and the array index
   logic              sec_start, sec_done;
   logic [SEC_W-1:0]  sec_rem;
   logic              idx_start, idx_done;
   logic [CELL_W-1:0] idx_rem;
   logic [ADDR_W-1:0] idx_div;

   logic [2:0]        phase_inc;
   logic              is_addr_cmd;
   logic              in_data;
   logic [ADDR_W-1:0] addr_shift;
   logic [CELL_W-1:0] cell_wrap;
   logic [CELL_W-1:0] cell_next;

   sfcs_rem #(.DIVISOR(SECTOR_BYTES)) u_sec_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (sec_start),
      .dividend  (addr_shift),
      .done      (sec_done),
      .remainder (sec_rem)
   );

   sfcs_rem #(.DIVISOR(MEM_BYTES)) u_idx_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (idx_start),
      .dividend  (idx_div),
      .done      (idx_done),
      .remainder (idx_rem)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_miso_byte = rsp_miso_ff;
   assign csr_ready     = 1'b1;

   assign phase_inc   = (phase_ff < PHASE_MAX) ? phase_ff + 3'd1 : phase_ff;
   assign is_addr_cmd = (cmd_ff == OP_READ) || (cmd_ff == OP_FAST_READ) ||
                        (cmd_ff == OP_PROGRAM) || (cmd_ff == OP_SECTOR_ERASE);
   // the fast read spends one more byte as a dummy
   assign in_data     = phase_inc > ((cmd_ff == OP_FAST_READ) ? PHASE_DMY : PHASE_ADDR);
   assign addr_shift  = {addr_ff[ADDR_W-9:0], req_mosi_byte};
   assign cell_wrap   = (cell_ff == CELL_W'(MEM_BYTES - 1)) ? '0 : cell_ff + CELL_W'(1);
   // the index follows the 24-bit address, which wraps on its own
   assign cell_next   = (addr_ff == ADDR_MAX) ? '0 : cell_wrap;

   always_comb begin
      state_in      = state_ff;
      present_in    = csr_valid ? csr_wdata : present_ff;
      cmd_in        = cmd_ff;
      phase_in      = phase_ff;
      addr_in       = addr_ff;
      latch_in      = latch_ff;
      cell_in       = cell_ff;
      cnt_in        = cnt_ff;
      mosi_in       = mosi_ff;
      rsp_strobe_in = 1'b0;
      rsp_miso_in   = rsp_miso_ff;
      mem_we        = 1'b0;
      mem_wdata     = IDLE_BYTE;
      sec_start     = 1'b0;
      idx_start     = 1'b0;
      idx_div       = addr_shift;

      case (state_ff)
         ST_CLEAR: begin
            // erase pass: fill every entry, then release
            mem_we  = 1'b1;
            cell_in = cell_wrap;
            if (cell_ff == CELL_W'(MEM_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_func) begin
                  // deselect: drop the command, no result word
                  cmd_in   = OP_NONE;
                  phase_in = '0;
               end else if (!present_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_miso_in   = IDLE_BYTE;
               end else if (cmd_ff == OP_NONE) begin
                  // command byte
                  cmd_in        = req_mosi_byte;
                  phase_in      = '0;
                  addr_in       = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_miso_in   = IDLE_BYTE;
                  if (req_mosi_byte == OP_WREN) begin
                     latch_in = 1'b1;
                  end else if (req_mosi_byte == OP_WRDI) begin
                     latch_in = 1'b0;
                  end else if (req_mosi_byte == OP_CHIP_ERASE && latch_ff) begin
                     cell_in  = '0;
                     state_in = ST_CLEAR;
                  end
               end else begin
                  phase_in      = phase_inc;
                  rsp_strobe_in = 1'b1;
                  rsp_miso_in   = IDLE_BYTE;
                  if (cmd_ff == OP_RDSR) begin
                     rsp_miso_in = latch_ff ? STATUS_WEL : STATUS_CLEAR;
                  end else if (is_addr_cmd) begin
                     if (phase_inc <= PHASE_ADDR) begin
                        addr_in = addr_shift;
                        if (phase_inc == PHASE_ADDR) begin
                           if (cmd_ff == OP_SECTOR_ERASE && latch_ff) begin
                              sec_start = 1'b1;
                              state_in  = ST_SREM;
                           end else begin
                              idx_start = 1'b1;
                              state_in  = ST_MREM;
                           end
                        end
                     end else if (in_data) begin
                        if (cmd_ff == OP_PROGRAM) begin
                           if (latch_ff) begin
                              // read now, AND and write back next cycle
                              mosi_in  = req_mosi_byte;
                              state_in = ST_PWR;
                           end else begin
                              addr_in = addr_ff + ADDR_W'(1);
                              cell_in = cell_next;
                           end
                        end else if (cmd_ff != OP_SECTOR_ERASE) begin
                           // read: memory is read at this edge, answer later
                           rsp_strobe_in = 1'b0;
                           addr_in       = addr_ff + ADDR_W'(1);
                           cell_in       = cell_next;
                           state_in      = ST_RDATA;
                        end
                     end
                  end
               end
            end
         end
         ST_MREM: begin
            if (idx_done) begin
               cell_in  = idx_rem;
               state_in = ST_IDLE;
            end
         end
         ST_SREM: begin
            // sector base known: reduce it to an array index
            idx_div = addr_ff - ADDR_W'(sec_rem);
            if (sec_done) begin
               idx_start = 1'b1;
               state_in  = ST_SREM2;
            end
         end
         ST_SREM2: begin
            if (idx_done) begin
               cell_in  = idx_rem;
               cnt_in   = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            mem_we  = 1'b1;
            cell_in = cell_wrap;
            cnt_in  = cnt_ff + SEC_W'(1);
            if (cnt_ff == SEC_W'(SECTOR_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_PWR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff & mosi_ff;
            addr_in   = addr_ff + ADDR_W'(1);
            cell_in   = cell_next;
            state_in  = ST_IDLE;
         end
         ST_RDATA: begin
            rsp_strobe_in = 1'b1;
            rsp_miso_in   = rd_data_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cell_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[cell_ff];
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      mosi_ff     <= mosi_in;
      rsp_miso_ff <= rsp_miso_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         present_ff    <= 1'b1;
         cmd_ff        <= OP_NONE;
         phase_ff      <= '0;
         latch_ff      <= 1'b0;
         cell_ff       <= '0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         present_ff    <= present_in;
         cmd_ff        <= cmd_in;
         phase_ff      <= phase_in;
         latch_ff      <= latch_in;
         cell_ff       <= cell_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

endmodule

/* hw/rtl/sfcs_rem.sv */
// Remainder by a constant through a reciprocal multiply. Capture the dividend,
// estimate the quotient, subtract the product, then correct once on the way
// out. done rises once the dividend has passed the a, q and r registers.
module sfcs_rem #(
   parameter int DIVISOR = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sfcs_pkg::ADDR_W-1:0] dividend,
   output logic                        done,
   output logic [$clog2(DIVISOR)-1:0]  remainder
);
   import sfcs_pkg::*;

   localparam int REM_W  = $clog2(DIVISOR);
   localparam int SHIFT  = ADDR_W + REM_W;
   localparam int PROD_W = 2 * ADDR_W + 1;
   // floor(2**SHIFT / DIVISOR) fits in ADDR_W + 1 bits; the quotient
   // estimate is never above the true one and at most one below it
   localparam logic [ADDR_W:0] RECIP =
      (ADDR_W + 1)'((longint'(1) << SHIFT) / longint'(DIVISOR));
   localparam logic [ADDR_W:0] DIV_C = (ADDR_W + 1)'(DIVISOR);

   logic [ADDR_W-1:0] a_ff, a_in;
   logic [ADDR_W-1:0] q_ff, q_in;
   logic [ADDR_W-1:0] r_ff, r_in;
   logic [2:0]        vld_ff, vld_in;
   logic [PROD_W-1:0] prod;
   logic [ADDR_W:0]   qm;
   logic [ADDR_W-1:0] r_fix;

   assign prod      = PROD_W'(a_ff) * PROD_W'(RECIP);
   assign qm        = (ADDR_W + 1)'(q_ff) * DIV_C;
   // partial remainder is below twice the divisor: one subtract settles it
   assign r_fix     = ({1'b0, r_ff} >= DIV_C) ? r_ff - DIV_C[ADDR_W-1:0] : r_ff;
   assign done      = vld_ff[2];
   assign remainder = r_fix[REM_W-1:0];

   always_comb begin
      a_in   = start ? dividend : a_ff;
      q_in   = ADDR_W'(prod >> SHIFT);
      r_in   = a_ff - qm[ADDR_W-1:0];
      vld_in = {vld_ff[1:0], start};
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      q_ff <= q_in;
      r_ff <= r_in;
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

endmodule

/* hw/rtl/sfcs_checker.sv */
module sfcs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_strobe
);
   logic xfer;
   logic desel;

   assign xfer  = start && !busy && !req_func;
   assign desel = start && !busy && req_func;

   // a result word answers a taken exchange, directly or after the memory read
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(xfer) || $past(xfer, 2)))
      else $error("result word without an exchange");

   // a deselect produces no word
   a_desel_silent: assert property (@(posedge clock) disable iff (reset)
      desel |=> !rsp_strobe)
      else $error("result word after deselect");

   // reset starts the clearing pass
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (busy && !rsp_strobe))
      else $error("not busy clearing after reset");

   // a taken exchange is followed by a result word or by busy
   a_xfer_answered: assert property (@(posedge clock) disable iff (reset)
      xfer |=> (rsp_strobe || busy))
      else $error("exchange dropped");

endmodule

bind spi_flash_command_slave_core sfcs_checker u_sfcs_checker (.*);
